// ----- design/gql_pkg.sv -----
package gql_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS   = 1;
   localparam int unsigned CSR_DATA_BITS    = 10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_HEIGHT  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHAR_SPACING = 1'd1;

   localparam int unsigned LINE_HEIGHT_BITS  = 10;
   localparam int unsigned CHAR_SPACING_BITS = 8;
   localparam logic [LINE_HEIGHT_BITS-1:0]  LINE_HEIGHT_RESET  = 10'd16;
   localparam logic [CHAR_SPACING_BITS-1:0] CHAR_SPACING_RESET = 8'd1;

   // text bytes and glyph mapping
   localparam int unsigned CODE_BITS  = 8;
   localparam int unsigned GLYPH_BITS = 7;
   localparam logic [CODE_BITS-1:0]  CODE_FIRST_PRINT = 8'd32;
   localparam logic [CODE_BITS-1:0]  CODE_LAST_PRINT  = 8'd127;
   localparam logic [CODE_BITS-1:0]  CODE_TAB         = 8'd9;
   localparam logic [CODE_BITS-1:0]  CODE_NEWLINE     = 8'd10;
   localparam logic [CODE_BITS-1:0]  CODE_FORM_FEED   = 8'd12;
   localparam logic [CODE_BITS-1:0]  CODE_CARRIAGE    = 8'd13;
   localparam logic [GLYPH_BITS-1:0] BAD_GLYPH        = 7'd95;
   localparam logic [GLYPH_BITS-1:0] TAB_GLYPH        = 7'd0;
   localparam int unsigned TAB_SHIFT = 3;

   // action codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_CHAR = 1'b1;

   // character kinds decided at the input register
   localparam int unsigned KIND_BITS = 2;
   localparam logic [KIND_BITS-1:0] KIND_DRAW  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_BREAK = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TAB   = 2'd2;

endpackage

// ----- design/glyph_quad_layout.sv -----
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  action, glyph_slot, glyph_width, char_code,
//                                          first, origin_x, origin_y, multi_line
// rsp      out        rsp_valid/rsp_stall  glyph, box_left, box_right, box_top, box_bottom
// csr      in         csr_write_en         csr_index, csr_write_data
//
// one item per cycle while req_stall is low; a drawn glyph reaches rsp through the width
// table read register and stage 1 register, then the result register with the pen update
// synchronous reset clears pen, margin, line mode and the valid flags and sets the
// configuration registers to their reset values; the width table has no reset and must be loaded before use
// rsp_stall holds the result and the stage behind it, and req_stall rises once
// that stage is full
module glyph_quad_layout #(
   parameter int unsigned GLYPH_COUNT = 96,
   parameter int unsigned COORD_BITS  = 16,
   parameter int unsigned WIDTH_BITS  = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_action,
   input  logic [$clog2(GLYPH_COUNT)-1:0]           req_glyph_slot,
   input  logic [WIDTH_BITS-1:0]                    req_glyph_width,
   input  logic [gql_pkg::CODE_BITS-1:0]            req_char_code,
   input  logic                                     req_first,
   input  logic signed [COORD_BITS-1:0]             req_origin_x,
   input  logic signed [COORD_BITS-1:0]             req_origin_y,
   input  logic                                     req_multi_line,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [gql_pkg::GLYPH_BITS-1:0]           rsp_glyph,
   output logic signed [COORD_BITS-1:0]             rsp_box_left,
   output logic signed [COORD_BITS-1:0]             rsp_box_right,
   output logic signed [COORD_BITS-1:0]             rsp_box_top,
   output logic signed [COORD_BITS-1:0]             rsp_box_bottom,

   input  logic                                     csr_write_en,
   input  logic [gql_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [gql_pkg::CSR_DATA_BITS-1:0]        csr_write_data
);

   localparam int unsigned SLOT_BITS = $clog2(GLYPH_COUNT);
   localparam int unsigned EXT_BITS  = COORD_BITS + WIDTH_BITS + 4;
   localparam logic signed [EXT_BITS-1:0] COORD_MAX_EXT =
      EXT_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [EXT_BITS-1:0] COORD_MIN_EXT =
      EXT_BITS'(-(64'sd1 <<< (COORD_BITS - 1)));
   localparam logic [SLOT_BITS:0] SLOT_LIMIT = (SLOT_BITS + 1)'(GLYPH_COUNT);

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [EXT_BITS-1:0] v
   );
      logic signed [COORD_BITS-1:0] r;
      if (v > COORD_MAX_EXT) begin
         r = COORD_MAX_EXT[COORD_BITS-1:0];
      end else if (v < COORD_MIN_EXT) begin
         r = COORD_MIN_EXT[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [gql_pkg::LINE_HEIGHT_BITS-1:0]  line_height_ff;
   logic [gql_pkg::CHAR_SPACING_BITS-1:0] char_spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_height_ff  <= gql_pkg::LINE_HEIGHT_RESET;
         char_spacing_ff <= gql_pkg::CHAR_SPACING_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gql_pkg::CSR_LINE_HEIGHT: begin
               line_height_ff <= csr_write_data[gql_pkg::LINE_HEIGHT_BITS-1:0];
            end
            gql_pkg::CSR_CHAR_SPACING: begin
               char_spacing_ff <= csr_write_data[gql_pkg::CHAR_SPACING_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input side
   logic out_free;
   logic s1_valid_ff;
   logic req_transfer;
   logic char_transfer;
   logic load_transfer;

   assign out_free      = !rsp_valid || !rsp_stall;
   assign req_stall     = s1_valid_ff && !out_free;
   assign req_transfer  = req_valid && !req_stall;
   assign char_transfer = req_transfer && (req_action == gql_pkg::ACTION_CHAR);
   assign load_transfer = req_transfer && (req_action == gql_pkg::ACTION_LOAD);

   // classify the byte
   logic [gql_pkg::KIND_BITS-1:0]  kind_in;
   logic [gql_pkg::GLYPH_BITS-1:0] glyph_in;
   logic [SLOT_BITS-1:0]           rd_addr;

   always_comb begin
      priority if (req_char_code >= gql_pkg::CODE_FIRST_PRINT &&
                   req_char_code <= gql_pkg::CODE_LAST_PRINT) begin
         kind_in  = gql_pkg::KIND_DRAW;
         glyph_in = gql_pkg::GLYPH_BITS'(req_char_code - gql_pkg::CODE_FIRST_PRINT);
      end else if (req_char_code == gql_pkg::CODE_NEWLINE ||
                   req_char_code == gql_pkg::CODE_FORM_FEED ||
                   req_char_code == gql_pkg::CODE_CARRIAGE) begin
         kind_in  = gql_pkg::KIND_BREAK;
         glyph_in = gql_pkg::BAD_GLYPH;
      end else if (req_char_code == gql_pkg::CODE_TAB) begin
         kind_in  = gql_pkg::KIND_TAB;
         glyph_in = gql_pkg::TAB_GLYPH;
      end else begin
         kind_in  = gql_pkg::KIND_DRAW;
         glyph_in = gql_pkg::BAD_GLYPH;
      end
   end

   assign rd_addr = SLOT_BITS'(glyph_in);

   // width table
   logic [WIDTH_BITS-1:0] width_mem [GLYPH_COUNT];
   logic [WIDTH_BITS-1:0] rd_width_ff;

   always_ff @(posedge clock) begin
      if (load_transfer && ({1'b0, req_glyph_slot} < SLOT_LIMIT)) begin
         width_mem[req_glyph_slot] <= req_glyph_width;
      end
   end

   always_ff @(posedge clock) begin
      if (char_transfer) begin
         rd_width_ff <= width_mem[rd_addr];
      end
   end

   // stage 1 register
   logic                           s1_valid_in;
   logic [gql_pkg::KIND_BITS-1:0]  s1_kind_ff;
   logic [gql_pkg::GLYPH_BITS-1:0] s1_glyph_ff;
   logic                           s1_first_ff;
   logic signed [COORD_BITS-1:0]   s1_origin_x_ff;
   logic signed [COORD_BITS-1:0]   s1_origin_y_ff;
   logic                           s1_multi_ff;

   always_comb begin
      if (char_transfer) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_transfer) begin
         s1_kind_ff     <= kind_in;
         s1_glyph_ff    <= glyph_in;
         s1_first_ff    <= req_first;
         s1_origin_x_ff <= req_origin_x;
         s1_origin_y_ff <= req_origin_y;
         s1_multi_ff    <= req_multi_line;
      end
   end

   // pen state
   logic signed [COORD_BITS-1:0] pen_x_ff;
   logic signed [COORD_BITS-1:0] pen_y_ff;
   logic signed [COORD_BITS-1:0] margin_ff;
   logic                         line_mode_ff;

   // stage 2 arithmetic, with a first item's origin applied ahead of the byte
   logic signed [COORD_BITS-1:0] base_x;
   logic signed [COORD_BITS-1:0] base_y;
   logic signed [COORD_BITS-1:0] margin_in;
   logic                         line_mode_in;
   logic signed [EXT_BITS-1:0]   base_x_ext;
   logic signed [EXT_BITS-1:0]   base_y_ext;
   logic signed [EXT_BITS-1:0]   width_ext;
   logic signed [EXT_BITS-1:0]   spacing_ext;
   logic signed [EXT_BITS-1:0]   height_ext;
   logic signed [COORD_BITS-1:0] right_x;
   logic signed [COORD_BITS-1:0] bottom_y;
   logic signed [COORD_BITS-1:0] advance_x;
   logic signed [COORD_BITS-1:0] tab_x;
   logic signed [COORD_BITS-1:0] pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_in;
   logic                         emit;

   always_comb begin
      base_x       = s1_first_ff ? s1_origin_x_ff : pen_x_ff;
      base_y       = s1_first_ff ? s1_origin_y_ff : pen_y_ff;
      margin_in    = s1_first_ff ? s1_origin_x_ff : margin_ff;
      line_mode_in = s1_first_ff ? s1_multi_ff : line_mode_ff;

      base_x_ext  = EXT_BITS'(base_x);
      base_y_ext  = EXT_BITS'(base_y);
      width_ext   = EXT_BITS'(rd_width_ff);
      spacing_ext = EXT_BITS'(char_spacing_ff);
      height_ext  = EXT_BITS'(line_height_ff);

      right_x   = sat_coord(base_x_ext + width_ext);
      bottom_y  = sat_coord(base_y_ext - height_ext);
      advance_x = sat_coord(base_x_ext + width_ext + spacing_ext);
      tab_x     = sat_coord(base_x_ext + (width_ext <<< gql_pkg::TAB_SHIFT));

      unique case (s1_kind_ff)
         gql_pkg::KIND_BREAK: begin
            if (line_mode_in) begin
               emit     = 1'b0;
               pen_x_in = margin_in;
               pen_y_in = bottom_y;
            end else begin
               emit     = 1'b1;
               pen_x_in = advance_x;
               pen_y_in = base_y;
            end
         end
         gql_pkg::KIND_TAB: begin
            emit     = 1'b0;
            pen_x_in = tab_x;
            pen_y_in = base_y;
         end
         default: begin
            emit     = 1'b1;
            pen_x_in = advance_x;
            pen_y_in = base_y;
         end
      endcase
   end

   logic s1_move;
   assign s1_move = s1_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         margin_ff    <= '0;
         line_mode_ff <= 1'b0;
      end else if (s1_move) begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         margin_ff    <= margin_in;
         line_mode_ff <= line_mode_in;
      end
   end

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [gql_pkg::GLYPH_BITS-1:0] rsp_glyph_ff;
   logic signed [COORD_BITS-1:0]   rsp_left_ff;
   logic signed [COORD_BITS-1:0]   rsp_right_ff;
   logic signed [COORD_BITS-1:0]   rsp_top_ff;
   logic signed [COORD_BITS-1:0]   rsp_bottom_ff;

   always_comb begin
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && emit) begin
         rsp_glyph_ff  <= s1_glyph_ff;
         rsp_left_ff   <= base_x;
         rsp_right_ff  <= right_x;
         rsp_top_ff    <= base_y;
         rsp_bottom_ff <= bottom_y;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_glyph      = rsp_glyph_ff;
   assign rsp_box_left   = rsp_left_ff;
   assign rsp_box_right  = rsp_right_ff;
   assign rsp_box_top    = rsp_top_ff;
   assign rsp_box_bottom = rsp_bottom_ff;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GLYPHS      = 96;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int COORD_HI    = 32767;
   localparam int COORD_LO    = -32768;

   typedef struct packed {
      logic        action;
      logic [6:0]  glyph_slot;
      logic [7:0]  glyph_width;
      logic [7:0]  char_code;
      logic        first;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic        multi_line;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  glyph;
      logic [15:0] box_left;
      logic [15:0] box_right;
      logic [15:0] box_top;
      logic [15:0] box_bottom;
   } glyph_box_type;

   localparam int ITEM_BITS = $bits(req_item_type);

   class layout_scoreboard;
      bit [7:0]       widths [GLYPHS];
      int             pen_x, pen_y, margin_x;
      bit             line_mode;
      int             line_height, spacing;
      glyph_box_type  expected_boxes [$];
      int             mismatches, boxes_checked, breaks, tabs, loads, chars;

      function new();
         pen_x = 0;
         pen_y = 0;
         margin_x = 0;
         line_mode = 1'b0;
         line_height = int'(gql_pkg::LINE_HEIGHT_RESET);
         spacing = int'(gql_pkg::CHAR_SPACING_RESET);
      endfunction

      function int clamp(int v);
         if (v > COORD_HI) return COORD_HI;
         if (v < COORD_LO) return COORD_LO;
         return v;
      endfunction

      function void set_reg(logic [gql_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [gql_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == gql_pkg::CSR_LINE_HEIGHT)
            line_height = int'(data[gql_pkg::LINE_HEIGHT_BITS-1:0]);
         else if (idx == gql_pkg::CSR_CHAR_SPACING)
            spacing = int'(data[gql_pkg::CHAR_SPACING_BITS-1:0]);
      endfunction

      function void place_glyph(logic [6:0] g);
         glyph_box_type b;
         int w;
         w = int'(widths[g]);
         b.glyph      = g;
         b.box_left   = pen_x[15:0];
         b.box_right  = 16'(clamp(pen_x + w));
         b.box_top    = pen_y[15:0];
         b.box_bottom = 16'(clamp(pen_y - line_height));
         expected_boxes.push_back(b);
         pen_x = clamp(pen_x + w + spacing);
      endfunction

      function void note_transfer(req_item_type it);
         logic [7:0] c;
         if (it.action == gql_pkg::ACTION_LOAD) begin
            loads++;
            if (it.glyph_slot < GLYPHS) widths[it.glyph_slot] = it.glyph_width;
            return;
         end
         chars++;
         if (it.first) begin
            pen_x = int'($signed(it.origin_x));
            pen_y = int'($signed(it.origin_y));
            margin_x = pen_x;
            line_mode = it.multi_line;
         end
         c = it.char_code;
         if (c >= gql_pkg::CODE_FIRST_PRINT && c <= gql_pkg::CODE_LAST_PRINT) begin
            place_glyph(7'(c - gql_pkg::CODE_FIRST_PRINT));
         end else if (c == gql_pkg::CODE_NEWLINE || c == gql_pkg::CODE_FORM_FEED ||
                      c == gql_pkg::CODE_CARRIAGE) begin
            if (line_mode) begin
               breaks++;
               pen_y = clamp(pen_y - line_height);
               pen_x = margin_x;
            end else begin
               place_glyph(gql_pkg::BAD_GLYPH);
            end
         end else if (c == gql_pkg::CODE_TAB) begin
            tabs++;
            pen_x = clamp(pen_x + (int'(widths[gql_pkg::TAB_GLYPH]) << gql_pkg::TAB_SHIFT));
         end else begin
            place_glyph(gql_pkg::BAD_GLYPH);
         end
      endfunction

      function void check_box(glyph_box_type got);
         glyph_box_type exp;
         if (expected_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: glyph %0d box %0d %0d %0d %0d", got.glyph,
                        $signed(got.box_left), $signed(got.box_right),
                        $signed(got.box_top), $signed(got.box_bottom));
            return;
         end
         exp = expected_boxes.pop_front();
         boxes_checked++;
         if (exp.glyph !== got.glyph || exp.box_left !== got.box_left ||
             exp.box_right !== got.box_right || exp.box_top !== got.box_top ||
             exp.box_bottom !== got.box_bottom) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("box mismatch: expected glyph %0d l/r/t/b %0d %0d %0d %0d",
                        exp.glyph, $signed(exp.box_left), $signed(exp.box_right),
                        $signed(exp.box_top), $signed(exp.box_bottom));
               $display("              got glyph %0d l/r/t/b %0d %0d %0d %0d",
                        got.glyph, $signed(got.box_left), $signed(got.box_right),
                        $signed(got.box_top), $signed(got.box_bottom));
            end
         end
      endfunction

      function int boxes_outstanding();
         return expected_boxes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [6:0]  req_glyph_slot;
   logic [7:0]  req_glyph_width;
   logic [gql_pkg::CODE_BITS-1:0] req_char_code;
   logic        req_first;
   logic signed [15:0] req_origin_x;
   logic signed [15:0] req_origin_y;
   logic        req_multi_line;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [gql_pkg::GLYPH_BITS-1:0] rsp_glyph;
   logic signed [15:0] rsp_box_left;
   logic signed [15:0] rsp_box_right;
   logic signed [15:0] rsp_box_top;
   logic signed [15:0] rsp_box_bottom;
   logic        csr_write_en;
   logic [gql_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [gql_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   layout_scoreboard sb;
   bit  slot_loaded [GLYPHS];
   bit  quiet;
   bit  hold_request;
   bit  hold_done;
   int  cycle_count;
   int  sent_items;

   glyph_quad_layout DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_glyph_slot (req_glyph_slot),
      .req_glyph_width(req_glyph_width),
      .req_char_code  (req_char_code),
      .req_first      (req_first),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_multi_line (req_multi_line),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_glyph      (rsp_glyph),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_right  (rsp_box_right),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_bottom (rsp_box_bottom),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // transfers seen on both channels
   always @(posedge clock) begin
      req_item_type  it;
      glyph_box_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            it = {req_action, req_glyph_slot, req_glyph_width, req_char_code, req_first,
                  req_origin_x, req_origin_y, req_multi_line};
            sb.note_transfer(it);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_glyph, rsp_box_left, rsp_box_right, rsp_box_top, rsp_box_bottom};
            sb.check_box(got);
         end
      end
   end

   // result side stalls, plus one long hold-off to back the block up
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   function automatic req_item_type noise_item();
      req_item_type it;
      it = ITEM_BITS'({$urandom, $urandom});
      return it;
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'(COORD_HI - int'($urandom_range(0, 300)));
         1: return 16'(COORD_LO + int'($urandom_range(0, 300)));
         2: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_width();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 8'(gql_pkg::CODE_FIRST_PRINT + $urandom_range(0, 95));
      if (r < 14) begin
         case ($urandom_range(0, 2))
            0: return gql_pkg::CODE_NEWLINE;
            1: return gql_pkg::CODE_FORM_FEED;
            default: return gql_pkg::CODE_CARRIAGE;
         endcase
      end
      if (r == 14) return gql_pkg::CODE_TAB;
      if (r == 15) return 8'($urandom_range(0, 31));
      if (r == 16) return 8'(128 + $urandom_range(0, 127));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(req_item_type it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= it.action;
      req_glyph_slot  <= it.glyph_slot;
      req_glyph_width <= it.glyph_width;
      req_char_code   <= it.char_code;
      req_first       <= it.first;
      req_origin_x    <= it.origin_x;
      req_origin_y    <= it.origin_y;
      req_multi_line  <= it.multi_line;
      do @(posedge clock); while (req_stall);
      if (it.action == gql_pkg::ACTION_LOAD && it.glyph_slot < GLYPHS)
         slot_loaded[it.glyph_slot] = 1'b1;
      sent_items++;
   endtask

   task automatic load_width(int slot, logic [7:0] w);
      req_item_type it;
      it = noise_item();
      it.action      = gql_pkg::ACTION_LOAD;
      it.glyph_slot  = 7'(slot);
      it.glyph_width = w;
      send_item(it);
   endtask

   // loads the glyph's width first when it has never been written
   task automatic send_char(logic [7:0] code, logic first, logic [15:0] ox, logic [15:0] oy,
                            logic multi);
      req_item_type it;
      if (code >= gql_pkg::CODE_FIRST_PRINT && code <= gql_pkg::CODE_LAST_PRINT &&
          !slot_loaded[code - gql_pkg::CODE_FIRST_PRINT])
         load_width(int'(code - gql_pkg::CODE_FIRST_PRINT), pick_width());
      it = noise_item();
      it.action     = gql_pkg::ACTION_CHAR;
      it.char_code  = code;
      it.first      = first;
      it.origin_x   = ox;
      it.origin_y   = oy;
      it.multi_line = multi;
      send_item(it);
   endtask

   task automatic write_reg(logic [gql_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [gql_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // loads, tabs and multi-line breaks give no result, so let the pipeline empty as well
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.boxes_outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_directed();
      load_width(0, 8'd5);
      load_width(95, 8'd255);
      load_width(1, 8'd0);
      load_width(127, 8'hAA);
      load_width(96, 8'h55);
      send_char(gql_pkg::CODE_FIRST_PRINT, 1'b1, 16'd0, 16'd0, 1'b1);
      send_char(8'd33, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_LAST_PRINT, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_TAB, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_NEWLINE, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_FORM_FEED, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_CARRIAGE, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(8'd0, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
      send_char(8'd255, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
      send_char(8'd128, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
      send_char(8'd31, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
      // line breaks without multi-line draw the bad glyph, right edge saturates
      send_char(gql_pkg::CODE_NEWLINE, 1'b1, 16'h7FFF, 16'h7FFF, 1'b0);
      send_char(gql_pkg::CODE_CARRIAGE, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
      // bottom edge and pen y saturate low
      send_char(8'd65, 1'b1, 16'h8000, 16'h8000, 1'b1);
      send_char(gql_pkg::CODE_NEWLINE, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_LAST_PRINT, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
      send_char(gql_pkg::CODE_TAB, 1'b1, 16'd32760, 16'd100, 1'b1);
      send_char(8'd126, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic run_random(int count, bit do_hold, bit go_quiet);
      for (int i = 0; i < count; i++) begin
         if (do_hold && i == 100) hold_request = 1'b1;
         if (go_quiet && i == count - 300) quiet = 1'b1;
         if ($urandom_range(0, 99) < 8)
            load_width($urandom_range(0, 127), pick_width());
         else if ($urandom_range(0, 11) == 0)
            send_char(pick_code(), 1'b1, pick_coord(), pick_coord(), 1'($urandom));
         else
            send_char(pick_code(), 1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      req_valid       <= 1'b0;
      req_action      <= gql_pkg::ACTION_LOAD;
      req_glyph_slot  <= '0;
      req_glyph_width <= '0;
      req_char_code   <= '0;
      req_first       <= 1'b0;
      req_origin_x    <= '0;
      req_origin_y    <= '0;
      req_multi_line  <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_index       <= gql_pkg::CSR_LINE_HEIGHT;
      csr_write_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the registers
      run_directed();
      run_random(350, 1'b0, 1'b0);
      settle();

      write_reg(gql_pkg::CSR_LINE_HEIGHT, 10'd1023);
      write_reg(gql_pkg::CSR_CHAR_SPACING, 10'd255);
      run_random(350, 1'b1, 1'b0);
      settle();

      // zero line height; spacing bits above the register width are dropped
      write_reg(gql_pkg::CSR_LINE_HEIGHT, 10'd0);
      write_reg(gql_pkg::CSR_CHAR_SPACING, 10'h300);
      run_random(350, 1'b0, 1'b0);
      settle();

      write_reg(gql_pkg::CSR_LINE_HEIGHT, 10'd1);
      write_reg(gql_pkg::CSR_CHAR_SPACING, {2'b01, 8'($urandom)});
      run_random(350, 1'b0, 1'b0);
      settle();

      write_reg(gql_pkg::CSR_LINE_HEIGHT, 10'($urandom_range(1, 1023)));
      write_reg(gql_pkg::CSR_CHAR_SPACING, 10'($urandom_range(0, 255)));
      run_random(350, 1'b0, 1'b1);
      settle();

      $display("sent %0d items: %0d width loads, %0d characters",
               sent_items, sb.loads, sb.chars);
      $display("checked %0d glyph boxes, %0d line breaks, %0d tabs, %0d mismatching",
               sb.boxes_checked, sb.breaks, sb.tabs, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
